// ===== rtl/core/scp_pkg.sv =====
package scp_pkg;

    localparam int CW   = 32;
    localparam int RW   = 31;
    localparam int SQW  = 2 * RW;
    localparam int NUMW = SQW + 1;
    localparam int QW   = 32;
    localparam int NSQ  = RW;
    localparam int NDIV = QW;

    localparam logic [1:0] K_PASS   = 2'd0;
    localparam logic [1:0] K_CENTER = 2'd1;
    localparam logic [1:0] K_PROJ   = 2'd2;

    typedef logic [1:0] t_kind;

    typedef struct packed {
        logic [CW-1:0] pos_x;
        logic [CW-1:0] pos_y;
        logic [CW-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [CW-1:0] out_x;
        logic [CW-1:0] out_y;
        logic [CW-1:0] out_z;
        logic          collided;
    } t_out;

    typedef struct packed {
        logic [2:0][CW-1:0] ctr;
        logic [RW-1:0]      radius;
    } t_cfg;

    typedef struct packed {
        t_kind               kind;
        t_in                 pos;
        logic [2:0]          neg;
        logic [SQW-1:0]      d2;
        logic [2:0][SQW-1:0] mr;
    } t_mid;

    typedef struct packed {
        t_kind               kind;
        t_in                 pos;
        logic [2:0]          neg;
        logic [2:0][SQW-1:0] mr;
        logic [SQW-1:0]      x;
        logic [SQW-1:0]      res;
    } t_sq;

    typedef struct packed {
        t_kind              kind;
        t_in                pos;
        logic [2:0]         neg;
        logic [RW-1:0]      n;
        logic [2:0][QW-1:0] rem;
        logic [2:0][QW-1:0] lo;
        logic [2:0][QW-1:0] q;
    } t_dv;

endpackage

// ===== rtl/core/scp_queue.sv =====
module scp_queue import scp_pkg::*; #(
    parameter int  DEPTH = 4,
    parameter type T     = t_mid
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [NW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + NW'(do_push) - NW'(do_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH)) else $error("queue count out of range");
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> r_cnt == NW'(DEPTH)) else $error("queue overflow");
    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> r_wp == r_rp) else $error("queue pointers out of step");

endmodule

// ===== rtl/core/scp_front.sv =====
module scp_front import scp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_push,
    input  t_in  i_data,
    output logic o_full,
    output logic o_push,
    output t_mid o_data,
    input  logic i_q_full
);

    logic                en;
    logic [2:0][CW-1:0]  pv;
    logic [2:0][CW:0]    dv;
    logic [2:0][CW:0]    mv;

    logic                r_v1;
    t_in                 r_p1;
    logic [2:0][CW:0]    r_m1;
    logic [2:0]          r_neg1;

    logic                r_v2;
    t_in                 r_p2;
    logic [2:0]          r_neg2;
    logic [2:0][SQW-1:0] r_sq2;
    logic [2:0][SQW-1:0] r_mr2;
    logic [SQW-1:0]      r_rsq2;
    logic                r_big2;

    logic                r_v3;
    t_mid                r_o3;

    logic [SQW+1:0]      sum;
    logic                hit;
    logic [2:0]          big;

    assign en     = !r_v3 || !i_q_full;
    assign o_full = !en;
    assign o_push = r_v3 && !i_q_full;
    assign o_data = r_o3;

    assign pv = {i_data.pos_x, i_data.pos_y, i_data.pos_z};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv[i] = {pv[i][CW-1], pv[i]} - {i_cfg.ctr[i][CW-1], i_cfg.ctr[i]};
            mv[i] = dv[i][CW] ? (CW+1)'(0) - dv[i] : dv[i];
            big[i] = r_m1[i] >= {2'b00, i_cfg.radius};
        end
    end

    assign sum = {2'b00, r_sq2[0]} + {2'b00, r_sq2[1]} + {2'b00, r_sq2[2]};
    assign hit = !r_big2 && (sum < {2'b00, r_rsq2});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= i_data;
            r_m1 <= mv;
            for (int i = 0; i < 3; i++) begin
                r_neg1[i] <= dv[i][CW];
            end
            r_p2   <= r_p1;
            r_neg2 <= r_neg1;
            for (int i = 0; i < 3; i++) begin
                r_sq2[i] <= r_m1[i][RW-1:0] * r_m1[i][RW-1:0];
                r_mr2[i] <= r_m1[i][RW-1:0] * i_cfg.radius;
            end
            r_rsq2 <= i_cfg.radius * i_cfg.radius;
            r_big2 <= |big;
            r_o3.pos <= r_p2;
            r_o3.neg <= r_neg2;
            r_o3.mr  <= r_mr2;
            r_o3.d2  <= sum[SQW-1:0];
            if (!hit) begin
                r_o3.kind <= K_PASS;
            end else if (sum == '0) begin
                r_o3.kind <= K_CENTER;
            end else begin
                r_o3.kind <= K_PROJ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

endmodule

// ===== rtl/core/scp_back.sv =====
module scp_back import scp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_mid i_data,
    output logic o_take,
    output logic o_empty,
    output t_out o_data,
    input  logic i_pop
);

    logic                en;
    logic                r_sv [NSQ+1];
    t_sq                 r_s  [NSQ+1];
    logic                r_dvv [NDIV+1];
    t_dv                 r_d   [NDIV+1];
    logic                r_ov;
    t_out                r_o;
    logic [NUMW-1:0]     num [3];
    logic [2:0][CW-1:0]  res;
    logic [2:0][CW-1:0]  pv;
    logic [CW+1:0]       so  [3];
    logic [CW+1:0]       sv  [3];

    assign en      = !r_ov || i_pop;
    assign o_take  = en && i_valid;
    assign o_empty = !r_ov;
    assign o_data  = r_o;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0].kind <= i_data.kind;
            r_s[0].pos  <= i_data.pos;
            r_s[0].neg  <= i_data.neg;
            r_s[0].mr   <= i_data.mr;
            r_s[0].x    <= i_data.d2;
            r_s[0].res  <= '0;
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
        logic [SQW-1:0] t;
        assign t = r_s[k].res + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s[k+1].kind <= r_s[k].kind;
                r_s[k+1].pos  <= r_s[k].pos;
                r_s[k+1].neg  <= r_s[k].neg;
                r_s[k+1].mr   <= r_s[k].mr;
                if (r_s[k].x >= t) begin
                    r_s[k+1].x   <= r_s[k].x - t;
                    r_s[k+1].res <= (r_s[k].res >> 1) + BIT;
                end else begin
                    r_s[k+1].x   <= r_s[k].x;
                    r_s[k+1].res <= r_s[k].res >> 1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = {1'b0, r_s[NSQ].mr[i]} + NUMW'(r_s[NSQ].res[RW-1:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0].kind <= r_s[NSQ].kind;
            r_d[0].pos  <= r_s[NSQ].pos;
            r_d[0].neg  <= r_s[NSQ].neg;
            r_d[0].n    <= r_s[NSQ].res[RW-1:0];
            for (int i = 0; i < 3; i++) begin
                r_d[0].rem[i] <= QW'(num[i][NUMW-1:QW]);
                r_d[0].lo[i]  <= num[i][QW-1:0];
                r_d[0].q[i]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [QW-1:0] w [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w[i] = {r_d[k].rem[i][QW-2:0], r_d[k].lo[i][QW-1]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[k+1].kind <= r_d[k].kind;
                r_d[k+1].pos  <= r_d[k].pos;
                r_d[k+1].neg  <= r_d[k].neg;
                r_d[k+1].n    <= r_d[k].n;
                for (int i = 0; i < 3; i++) begin
                    r_d[k+1].lo[i] <= {r_d[k].lo[i][QW-2:0], 1'b0};
                    if (w[i] >= {1'b0, r_d[k].n}) begin
                        r_d[k+1].rem[i] <= w[i] - {1'b0, r_d[k].n};
                        r_d[k+1].q[i]   <= {r_d[k].q[i][QW-2:0], 1'b1};
                    end else begin
                        r_d[k+1].rem[i] <= w[i];
                        r_d[k+1].q[i]   <= {r_d[k].q[i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign pv = {r_d[NDIV].pos.pos_x, r_d[NDIV].pos.pos_y, r_d[NDIV].pos.pos_z};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            so[i] = r_d[NDIV].neg[i] ? (CW+2)'(0) - {2'b00, r_d[NDIV].q[i]}
                                     : {2'b00, r_d[NDIV].q[i]};
            sv[i] = {{2{i_cfg.ctr[i][CW-1]}}, i_cfg.ctr[i]} + so[i];
            if (sv[i][CW+1:CW-1] == 3'b000 || sv[i][CW+1:CW-1] == 3'b111) begin
                res[i] = sv[i][CW-1:0];
            end else begin
                res[i] = {sv[i][CW+1], {(CW-1){~sv[i][CW+1]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            case (r_d[NDIV].kind)
                K_PROJ: begin
                    {r_o.out_x, r_o.out_y, r_o.out_z} <= res;
                    r_o.collided <= 1'b1;
                end
                K_CENTER: begin
                    {r_o.out_x, r_o.out_y, r_o.out_z} <= i_cfg.ctr;
                    r_o.collided <= 1'b1;
                end
                default: begin
                    {r_o.out_x, r_o.out_y, r_o.out_z} <= pv;
                    r_o.collided <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSQ; k++) begin
                r_sv[k] <= 1'b0;
            end
            for (int k = 0; k <= NDIV; k++) begin
                r_dvv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_valid;
            for (int k = 0; k < NSQ; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_dvv[0] <= r_sv[NSQ];
            for (int k = 0; k < NDIV; k++) begin
                r_dvv[k+1] <= r_dvv[k];
            end
            r_ov <= r_dvv[NDIV];
        end
    end

endmodule

// ===== rtl/core/sphere_collision_projection.sv =====
// Path: push -> front pipeline -> queue -> back pipeline -> output register.
// Throughput: one transaction per cycle unless stalled; the front feeds a 4-entry
// queue and stalls on a full queue, and the back pipeline (31-step square root,
// 32-step divider per axis) advances when the output register is free or popped.
// Reset: synchronous active low; clears all valid bits, center to 0, radius to 1.0.
module sphere_collision_projection import scp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_in           i_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output t_out          o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [CW-1:0] i_cfg_data
);

    localparam logic [1:0] R_CX  = 2'd0;
    localparam logic [1:0] R_CY  = 2'd1;
    localparam logic [1:0] R_CZ  = 2'd2;
    localparam logic [1:0] R_RAD = 2'd3;

    t_cfg r_cfg;
    logic q_push;
    t_mid q_wdata;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_mid q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ctr    <= '0;
            r_cfg.radius <= RW'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                R_CX:    r_cfg.ctr[2]  <= i_cfg_data;
                R_CY:    r_cfg.ctr[1]  <= i_cfg_data;
                R_CZ:    r_cfg.ctr[0]  <= i_cfg_data;
                R_RAD:   r_cfg.radius  <= i_cfg_data[RW-1:0];
                default: r_cfg.radius  <= r_cfg.radius;
            endcase
        end
    end

    scp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (i_push),
        .i_data   (i_data),
        .o_full   (o_full),
        .o_push   (q_push),
        .o_data   (q_wdata),
        .i_q_full (q_full)
    );

    scp_queue #(
        .DEPTH (4),
        .T     (t_mid)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    scp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (!q_empty),
        .i_data  (q_rdata),
        .o_take  (q_pop),
        .o_empty (o_empty),
        .o_data  (o_data),
        .i_pop   (i_pop)
    );

endmodule
